[hw/rtl/cbd_pkg.sv]
// Shared types, constants and the ring-length remainder table for the deque.
// Used by cbd_ptr and circular_buffer_deque; no dependencies of its own.
package cbd_pkg;

    localparam int RING_SLOTS = 16;
    localparam int WORD_BITS  = 32;
    localparam int IDX_BITS   = $clog2(RING_SLOTS);
    localparam int CAP_BITS   = 4;
    localparam int CNT_BITS   = 4;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 4'd15;

    // Operation codes carried on the input tuser
    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_PUSH_FULL  = 2'd1,
        STAT_POP_EMPTY  = 2'd2
    } t_status;

    // Memory access issued for one transaction
    typedef struct packed {
        logic                we;
        logic                re;
        logic [IDX_BITS-1:0] addr;
    } t_ram_req;

    // Result fields known at issue time (popped word comes from the RAM)
    typedef struct packed {
        logic                pop_ok;
        t_status             status;
        logic [CNT_BITS-1:0] count;
        logic                empty;
        logic                full;
    } t_result;

    // Remainder of an index by the ring length (capacity + 1), for
    // every capacity and index: entry {cap, idx}. Built by counting.
    typedef logic [(1 << (CAP_BITS + IDX_BITS))-1:0][IDX_BITS-1:0] t_mod_tbl;

    function automatic t_mod_tbl build_mod_tbl();
        t_mod_tbl            tbl;
        logic [IDX_BITS-1:0] r;
        tbl = '0;
        for (int c = 0; c < (1 << CAP_BITS); c++) begin
            r = '0;
            for (int i = 0; i < (1 << IDX_BITS); i++) begin
                tbl[c * (1 << IDX_BITS) + i] = r;
                if (32'(r) >= c) begin
                    r = '0;
                end else begin
                    r = r + 1'b1;
                end
            end
        end
        return tbl;
    endfunction

    localparam t_mod_tbl MOD_TBL = build_mod_tbl();

endpackage

[hw/rtl/cbd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module cbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/cbd_ptr.sv]
// Head/tail pointers, capacity register and per-transaction decode.
// Depends on cbd_pkg.
module cbd_ptr (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_acc,
    input  cbd_pkg::t_mode                i_mode,
    input  logic                          i_cfg_we,
    input  logic [cbd_pkg::CAP_BITS-1:0]  i_cfg_data,
    output cbd_pkg::t_ram_req             o_req,
    output cbd_pkg::t_result              o_res
);

    logic [cbd_pkg::IDX_BITS-1:0] r_head, n_head;
    logic [cbd_pkg::IDX_BITS-1:0] r_tail, n_tail;
    logic [cbd_pkg::CAP_BITS-1:0] r_cap;

    logic [cbd_pkg::IDX_BITS-1:0] head_fwd, head_back, tail_fwd, tail_back;
    logic [cbd_pkg::IDX_BITS-1:0] head_mod, tail_mod;
    logic [cbd_pkg::IDX_BITS:0]   diff;
    logic [cbd_pkg::IDX_BITS:0]   len;
    logic                         is_empty, is_full, is_push, ok;

    // Wrap by comparison against length-1, which is the capacity
    always_comb begin
        head_fwd  = ({1'b0, r_head} >= {1'b0, r_cap}) ? '0 : r_head + 1'b1;
        tail_fwd  = ({1'b0, r_tail} >= {1'b0, r_cap}) ? '0 : r_tail + 1'b1;
        head_back = (r_head == '0) ? r_cap : r_head - 1'b1;
        tail_back = (r_tail == '0) ? r_cap : r_tail - 1'b1;
        is_empty  = (r_head == r_tail);
        is_full   = (tail_fwd == r_head);
        is_push   = (i_mode == cbd_pkg::MODE_PUSH_FRONT) ||
                    (i_mode == cbd_pkg::MODE_PUSH_BACK);
        ok        = is_push ? !is_full : !is_empty;
    end

    // Operation decode: memory access and next pointers
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        o_req.we  = 1'b0;
        o_req.re  = 1'b0;
        o_req.addr = r_head;
        unique case (i_mode)
            cbd_pkg::MODE_PUSH_FRONT: begin
                o_req.addr = head_back;
                o_req.we   = i_acc && ok;
                if (ok) n_head = head_back;
            end
            cbd_pkg::MODE_PUSH_BACK: begin
                o_req.addr = r_tail;
                o_req.we   = i_acc && ok;
                if (ok) n_tail = tail_fwd;
            end
            cbd_pkg::MODE_POP_FRONT: begin
                o_req.addr = r_head;
                o_req.re   = i_acc && ok;
                if (ok) n_head = head_fwd;
            end
            cbd_pkg::MODE_POP_BACK: begin
                o_req.addr = tail_back;
                o_req.re   = i_acc && ok;
                if (ok) n_tail = tail_back;
            end
            default: begin
                o_req.addr = r_head;
            end
        endcase
    end

    // Count after the operation: both indices reduced by the ring length,
    // then a signed difference folded back into range
    always_comb begin
        len      = {1'b0, r_cap} + 1'b1;
        head_mod = cbd_pkg::MOD_TBL[{r_cap, n_head}];
        tail_mod = cbd_pkg::MOD_TBL[{r_cap, n_tail}];
        diff     = {1'b0, tail_mod} - {1'b0, head_mod};
        if (diff[cbd_pkg::IDX_BITS]) begin
            diff = diff + len;
        end
        o_res.count  = diff[cbd_pkg::CNT_BITS-1:0];
        o_res.empty  = (n_head == n_tail);
        o_res.full   = (diff == {1'b0, r_cap});
        o_res.pop_ok = ok && !is_push;
        if (ok) begin
            o_res.status = cbd_pkg::STAT_DONE;
        end else if (is_push) begin
            o_res.status = cbd_pkg::STAT_PUSH_FULL;
        end else begin
            o_res.status = cbd_pkg::STAT_POP_EMPTY;
        end
    end

    // Pointer and capacity registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cap  <= cbd_pkg::CAP_RESET;
        end else begin
            if (i_acc) begin
                r_head <= n_head;
                r_tail <= n_tail;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
        end
    end

endmodule

[hw/rtl/circular_buffer_deque.sv]
// Double-ended queue in a ring of capacity+1 slots held in one RAM.
// Pipeline: stage 2 holds the result with the RAM read, then the output register.
// Throughput: 1 transaction/cycle unless stalled; set by the single RAM port pair.
// Reset: synchronous active-low; head, tail cleared, capacity 15, RAM not cleared.
// Depends on cbd_pkg, cbd_ptr, cbd_ram.
module circular_buffer_deque (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] data_in
    input  logic [1:0]  i_s_tuser,   // [1:0] mode
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] data_out, [35:32] count, [39:36] zero
    output logic [3:0]  o_m_tuser,   // [1:0] status, [2] now_empty, [3] now_full
    // Capacity register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data
);

    cbd_pkg::t_ram_req                 req;
    cbd_pkg::t_result                  res;
    cbd_pkg::t_result                  r_p_res;
    logic                              r_p_valid;
    logic                              r_o_valid;
    logic [cbd_pkg::WORD_BITS-1:0]     r_o_data;
    cbd_pkg::t_result                  r_o_res;
    logic [cbd_pkg::WORD_BITS-1:0]     rdata;
    logic                              acc, o_move;

    assign o_move      = !r_o_valid || i_m_tready;
    assign o_s_tready  = !r_p_valid || o_move;
    assign acc         = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    cbd_ptr u_ptr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_mode     (cbd_pkg::t_mode'(i_s_tuser)),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_req      (req),
        .o_res      (res)
    );

    // Read data only changes on a new pop, so it holds while stage 2 stalls
    cbd_ram #(
        .WIDTH (cbd_pkg::WORD_BITS),
        .DEPTH (cbd_pkg::RING_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (req.we),
        .i_waddr (req.addr),
        .i_wdata (i_s_tdata),
        .i_re    (req.re),
        .i_raddr (req.addr),
        .o_rdata (rdata)
    );

    // Stage 2 waits for RAM data; output register parts from the consumer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_p_valid <= 1'b1;
            end else if (o_move) begin
                r_p_valid <= 1'b0;
            end
            if (o_move) begin
                r_o_valid <= r_p_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_p_res <= res;
        end
        if (o_move && r_p_valid) begin
            r_o_res  <= r_p_res;
            r_o_data <= r_p_res.pop_ok ? rdata : '0;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {4'b0000, r_o_res.count, r_o_data};
    assign o_m_tuser  = {r_o_res.full, r_o_res.empty, r_o_res.status};

endmodule
